[design/assert_macros.svh]
// Assertion macros shared by the SHA-1 digest unit RTL.
// Properties are sampled on aclk and disabled while aresetn is low.
// Nothing here is visible to synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SHA1MD_ASSERT_PROP(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("SHA-1 digest unit assertion failed");
`define SHA1MD_ASSERT_NEVER(label, expr) \
    `SHA1MD_ASSERT_PROP(label, !(expr))
`else
`define SHA1MD_ASSERT_PROP(label, prop)
`define SHA1MD_ASSERT_NEVER(label, expr)
`endif

`endif

[design/sha1md_pkg.sv]
// Shared types and constants of the SHA-1 digest unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package sha1md_pkg;

    typedef logic [31:0] word_t;

    localparam word_t K_CH     = 32'h5a827999;
    localparam word_t K_PAR_LO = 32'h6ed9eba1;
    localparam word_t K_MAJ    = 32'h8f1bbcdc;
    localparam word_t K_PAR_HI = 32'hca62c1d6;

    localparam word_t H0 = 32'h67452301;
    localparam word_t H1 = 32'hefcdab89;
    localparam word_t H2 = 32'h98badcfe;
    localparam word_t H3 = 32'h10325476;
    localparam word_t H4 = 32'hc3d2e1f0;

    localparam logic [7:0] PAD_MARK        = 8'h80;
    localparam logic [5:0] BLOCK_LAST_POS  = 6'd63;
    localparam logic [5:0] LEN_PREV_POS    = 6'd55;
    localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_MARK,
        SEL_ZERO,
        SEL_LENGTH
    } byte_sel_t;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR_LO,
        PH_MAJ,
        PH_PAR_HI
    } round_phase_t;

    typedef struct packed {
        logic         byte_we;
        byte_sel_t    byte_sel;
        logic         len_inc;
        logic         load_work;
        logic         round_en;
        round_phase_t phase;
        logic         fold;
        logic         msg_clear;
        logic [2:0]   out_index;
    } cmd_t;

    typedef struct packed {
        logic [5:0] fill_pos;
    } status_t;

    function automatic word_t init_chain_word(input logic [2:0] idx);
        word_t w;
        unique case (idx)
            3'd0:    w = H0;
            3'd1:    w = H1;
            3'd2:    w = H2;
            3'd3:    w = H3;
            3'd4:    w = H4;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

[design/sha1md_datapath.sv]
// Datapath of the SHA-1 digest unit: block buffer used as the message
// schedule window, round registers, chaining value and message length.
// Depends on sha1md_pkg; driven by commands from sha1md_ctrl.
module sha1md_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          in_byte,
    input  sha1md_pkg::cmd_t    cmd,
    output sha1md_pkg::status_t status,
    output sha1md_pkg::word_t   digest_word
);
    import sha1md_pkg::*;

    word_t       block_reg [16];
    word_t       chain_reg [5];
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] bit_length_reg;
    logic [5:0]  fill_pos_reg;

    logic [7:0] wr_byte;
    logic [7:0] len_byte;
    word_t      sched_mix;
    word_t      sched_next;
    word_t      f_val;
    word_t      k_val;
    word_t      t_val;

    assign len_byte = bit_length_reg[{~fill_pos_reg[2:0], 3'b000} +: 8];

    always_comb begin
        unique case (cmd.byte_sel)
            SEL_INPUT:  wr_byte = in_byte;
            SEL_MARK:   wr_byte = PAD_MARK;
            SEL_ZERO:   wr_byte = '0;
            SEL_LENGTH: wr_byte = len_byte;
        endcase
    end

    assign sched_mix  = block_reg[13] ^ block_reg[8] ^ block_reg[2] ^ block_reg[0];
    assign sched_next = {sched_mix[30:0], sched_mix[31]};

    always_comb begin
        unique case (cmd.phase)
            PH_CH: begin
                f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
                k_val = K_CH;
            end
            PH_PAR_LO: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_PAR_LO;
            end
            PH_MAJ: begin
                f_val = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
                k_val = K_MAJ;
            end
            PH_PAR_HI: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_PAR_HI;
            end
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + block_reg[0] + k_val;

    always_ff @(posedge aclk) begin
        if (cmd.byte_we) begin
            block_reg[fill_pos_reg[5:2]][{~fill_pos_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end else if (cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                block_reg[i] <= block_reg[i + 1];
            end
            block_reg[15] <= sched_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_work) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (cmd.round_en) begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.msg_clear) begin
            for (int i = 0; i < 5; i++) begin
                chain_reg[i] <= init_chain_word(3'(i));
            end
            bit_length_reg <= '0;
            fill_pos_reg   <= '0;
        end else begin
            if (cmd.fold) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
            if (cmd.len_inc) begin
                bit_length_reg <= bit_length_reg + 64'd8;
            end
            if (cmd.byte_we) begin
                fill_pos_reg <= fill_pos_reg + 6'd1;
            end
        end
    end

    always_comb begin
        unique case (cmd.out_index)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            3'd4:    digest_word = chain_reg[4];
            default: digest_word = '0;
        endcase
    end

    assign status.fill_pos = fill_pos_reg;

endmodule

[design/sha1md_ctrl.sv]
// Controller of the SHA-1 digest unit: request handshakes, padding
// sequence, round counting and digest readout.
// Depends on sha1md_pkg and assert_macros.svh; commands sha1md_datapath.
`include "assert_macros.svh"

module sha1md_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2:0]          m_tuser,
    output logic                m_tlast,
    output sha1md_pkg::cmd_t    cmd,
    input  sha1md_pkg::status_t status
);
    import sha1md_pkg::*;

    localparam logic [6:0] LAST_ROUND    = 7'd79;
    localparam logic [6:0] PAR_LO_START  = 7'd20;
    localparam logic [6:0] MAJ_START     = 7'd40;
    localparam logic [6:0] PAR_HI_START  = 7'd60;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        P_MARK = 4'b0001,
        P_ZERO = 4'b0010,
        P_LEN  = 4'b0100,
        P_DONE = 4'b1000
    } pad_stage_t;

    state_t     state_reg, state_next;
    pad_stage_t stage_reg, stage_next;
    logic       end_reg, end_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] index_reg, index_next;

    logic in_acc;
    logic out_acc;
    logic block_end;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tuser   = index_reg;
    assign m_tlast   = (index_reg == LAST_WORD_INDEX);
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign block_end = (status.fill_pos == BLOCK_LAST_POS);

    always_comb begin
        state_next = state_reg;
        stage_next = stage_reg;
        end_next   = end_reg;
        round_next = round_reg;
        index_next = index_reg;

        cmd           = '0;
        cmd.byte_sel  = SEL_INPUT;
        cmd.phase     = PH_CH;
        cmd.out_index = index_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        cmd.byte_we = 1'b1;
                        cmd.len_inc = 1'b1;
                    end
                    if (s_tlast) begin
                        end_next   = 1'b1;
                        stage_next = P_MARK;
                    end
                    if (s_tuser && block_end) begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        state_next    = S_ROUND;
                    end else if (s_tlast) begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD: begin
                cmd.byte_we = 1'b1;
                unique case (stage_reg)
                    P_MARK:  cmd.byte_sel = SEL_MARK;
                    P_LEN:   cmd.byte_sel = SEL_LENGTH;
                    default: cmd.byte_sel = SEL_ZERO;
                endcase
                if (stage_reg == P_LEN) begin
                    if (block_end) begin
                        stage_next = P_DONE;
                    end
                end else if (status.fill_pos == LEN_PREV_POS) begin
                    stage_next = P_LEN;
                end else begin
                    stage_next = P_ZERO;
                end
                if (block_end) begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND: begin
                cmd.round_en = 1'b1;
                priority if (round_reg < PAR_LO_START) begin
                    cmd.phase = PH_CH;
                end else if (round_reg < MAJ_START) begin
                    cmd.phase = PH_PAR_LO;
                end else if (round_reg < PAR_HI_START) begin
                    cmd.phase = PH_MAJ;
                end else begin
                    cmd.phase = PH_PAR_HI;
                end
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                cmd.fold = 1'b1;
                if (!end_reg) begin
                    state_next = S_IDLE;
                end else if (stage_reg == P_DONE) begin
                    index_next = '0;
                    state_next = S_OUT;
                end else begin
                    state_next = S_PAD;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    if (index_reg == LAST_WORD_INDEX) begin
                        cmd.msg_clear = 1'b1;
                        end_next      = 1'b0;
                        stage_next    = P_MARK;
                        index_next    = '0;
                        state_next    = S_IDLE;
                    end else begin
                        index_next = index_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            stage_reg <= P_MARK;
            end_reg   <= 1'b0;
            round_reg <= '0;
            index_reg <= '0;
        end else begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            end_reg   <= end_next;
            round_reg <= round_next;
            index_reg <= index_next;
        end
    end

    `SHA1MD_ASSERT_NEVER(a_ready_excludes_output, s_tready && m_tvalid)
    `SHA1MD_ASSERT_NEVER(a_no_write_during_round, cmd.byte_we && cmd.round_en)
    `SHA1MD_ASSERT_PROP(a_round_count_ends, (state_reg == S_ROUND && round_reg == LAST_ROUND) |=> state_reg == S_FOLD)
    `SHA1MD_ASSERT_PROP(a_digest_block_aligned, (state_reg == S_FOLD && state_next == S_OUT) |-> status.fill_pos == '0)

endmodule

[design/sha1_message_digest_unit.sv]
// SHA-1 message digest unit, top level. Takes message bytes on a stream
// input, one byte per request, and returns the five digest words of each
// message on a stream output. A byte is taken whenever the unit is
// ready; every 64th byte starts the compression, which runs one round
// per cycle through a single round unit. The request with tlast closes
// the message: padding bytes are written one per cycle, the last one or
// two blocks are compressed, and the digest words follow most
// significant first, word 0 to word 4, with tlast on word 4. Input is
// held off during each compression, and from the request with tlast
// until the fifth word has been taken.
// Depends on sha1md_pkg, sha1md_ctrl and sha1md_datapath.
module sha1_message_digest_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);
    import sha1md_pkg::*;

    cmd_t    cmd;
    status_t status;

    sha1md_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

    sha1md_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_byte     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .digest_word (m_tdata)
    );

endmodule
